// ----- rtl/bks_pkg.sv -----
// Package for the bucketed key set: sizes, commands and shared types.
`default_nettype none
package bks_pkg;
    localparam int BUCKET_BITS = 8;
    localparam int WAYS        = 4;
    localparam int BUCKETS     = 1 << BUCKET_BITS;
    localparam int KEY_BITS    = 256;
    localparam int ROW_BITS    = KEY_BITS * WAYS;
    localparam int RAM_BITS    = ROW_BITS + WAYS;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // One classified operation handed from the front end to the back end.
    typedef struct packed {
        t_cmd                   cmd;
        logic [BUCKET_BITS-1:0] bucket;
        logic [KEY_BITS-1:0]    key;
    } t_op;
endpackage
`default_nettype wire

// ----- rtl/bks_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/bks_front.sv -----
// Front end: accepts words, picks the bucket, and queues operations.
`default_nettype none
module bks_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [63:0] i_key_w0,
    input  wire logic [63:0] i_key_w1,
    input  wire logic [63:0] i_key_w2,
    input  wire logic [63:0] i_key_w3,
    output logic             o_op_valid,
    input  wire logic        i_op_ready,
    output bks_pkg::t_op     o_op
);
    bks_pkg::t_op r_q [bks_pkg::QDEPTH];
    logic [1:0]   r_cnt;
    logic         r_wp, r_rp;
    logic         push, pop;
    bks_pkg::t_op op_in;

    always_comb begin
        op_in.cmd    = bks_pkg::t_cmd'(i_command);
        op_in.bucket = i_key_w0[63 -: bks_pkg::BUCKET_BITS];
        op_in.key    = {i_key_w0, i_key_w1, i_key_w2, i_key_w3};
    end

    assign o_ready    = (r_cnt != 2'd2);
    assign push       = i_valid && o_ready;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= op_in;
        end
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bks_back.sv -----
// Back end: reads a bucket row, compares all ways, writes back, and reports.
`default_nettype none
module bks_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_op_valid,
    output logic          o_op_ready,
    input  bks_pkg::t_op  i_op,
    output logic          o_valid,
    input  wire logic     i_ready,
    output logic          o_found,
    output logic          o_status
);
    typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_READ, S_OUT} t_state;

    t_state                            r_state;
    bks_pkg::t_op                      r_op;
    logic                              r_clear;
    logic [bks_pkg::BUCKET_BITS-1:0]   r_sweep;
    logic [bks_pkg::RAM_BITS-1:0]      rdata, wdata;
    logic [bks_pkg::BUCKET_BITS-1:0]   waddr;
    logic [bks_pkg::ROW_BITS-1:0]      row_keys, n_row_keys;
    logic                              we;
    logic [bks_pkg::WAYS-1:0]          row_v, hit_vec, n_row_v;
    logic                              hit, free_any, row_change;
    logic [bks_pkg::WAY_BITS-1:0]      hit_way, free_way;
    logic                              n_found, n_status;

    // Each row holds the valid flags of its ways above the ways' keys.
    bks_ram #(.WIDTH(bks_pkg::RAM_BITS), .DEPTH(bks_pkg::BUCKETS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(i_op.bucket),
        .o_rdata(rdata)
    );

    assign o_op_ready = (r_state == S_IDLE);
    assign row_keys   = rdata[bks_pkg::ROW_BITS-1:0];
    assign row_v      = rdata[bks_pkg::RAM_BITS-1 -: bks_pkg::WAYS];

    always_comb begin
        hit      = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = 0; w < bks_pkg::WAYS; w++) begin
            hit_vec[w] = row_v[w] &&
                (row_keys[w*bks_pkg::KEY_BITS +: bks_pkg::KEY_BITS] == r_op.key);
        end
        for (int w = bks_pkg::WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit     = 1'b1;
                hit_way = bks_pkg::WAY_BITS'(w);
            end
            if (!row_v[w]) begin
                free_any = 1'b1;
                free_way = bks_pkg::WAY_BITS'(w);
            end
        end
        // Only the chosen way's key changes; others write back as read.
        n_row_keys = row_keys;
        n_row_v    = row_v;
        row_change = 1'b0;
        n_found    = hit;
        n_status   = 1'b0;
        case (r_op.cmd)
            bks_pkg::CMD_INSERT: begin
                if (!hit) begin
                    if (free_any) begin
                        n_row_keys[free_way*bks_pkg::KEY_BITS +: bks_pkg::KEY_BITS] = r_op.key;
                        n_row_v[free_way] = 1'b1;
                        row_change        = 1'b1;
                    end else begin
                        n_status = 1'b1;
                    end
                end
            end
            bks_pkg::CMD_REMOVE: begin
                if (hit) begin
                    n_row_v[hit_way] = 1'b0;
                    row_change       = 1'b1;
                end
            end
            default: ;
        endcase
        // The sweep zeroes one row per cycle; otherwise only a changed row
        // is written back.
        if (r_state == S_SWEEP) begin
            we    = 1'b1;
            waddr = r_sweep;
            wdata = '0;
        end else begin
            we    = (r_state == S_READ) && row_change;
            waddr = r_op.bucket;
            wdata = {n_row_v, n_row_keys};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_sweep <= '0;
            r_clear <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (&r_sweep) begin
                        if (r_clear) begin
                            r_clear  <= 1'b0;
                            o_found  <= 1'b0;
                            o_status <= 1'b0;
                            o_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_op_valid) begin
                        r_op <= i_op;
                        if (i_op.cmd == bks_pkg::CMD_CLEAR) begin
                            r_clear <= 1'b1;
                            r_sweep <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    o_found  <= n_found;
                    o_status <= n_status;
                    o_valid  <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bucketed_key_set_unit.sv -----
// Top level of the bucketed key set: front-end queue plus bucket engine.
//
// Channel  Direction  Handshake              Payload
// input    in         i_valid / o_ready      i_command, i_key_w0..i_key_w3
// result   out        o_valid / i_ready      o_found, o_status
//
// The front end takes one word per cycle while its two-entry queue has room,
// so it keeps accepting while the back end works. The back end takes a word
// in S_IDLE while its bucket row is read, compares all ways and writes the row
// back in S_READ, then holds the result in S_OUT until it is taken, and takes
// no new word before that. A clear sweeps all 256 rows, one per cycle, and
// its result comes once the last row is zeroed. Reset is synchronous,
// empties the queue, and starts the same sweep of all 256 rows; the front
// end fills and stalls until the sweep ends.
`default_nettype none
module bucketed_key_set_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [63:0] i_key_w0,
    input  wire logic [63:0] i_key_w1,
    input  wire logic [63:0] i_key_w2,
    input  wire logic [63:0] i_key_w3,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic             o_status
);
    logic         op_valid, op_ready;
    bks_pkg::t_op op;

    // Front end: classifies each word by bucket and queues it.
    bks_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_command (i_command),
        .i_key_w0  (i_key_w0),
        .i_key_w1  (i_key_w1),
        .i_key_w2  (i_key_w2),
        .i_key_w3  (i_key_w3),
        .o_op_valid(op_valid),
        .i_op_ready(op_ready),
        .o_op      (op)
    );

    // Back end: read-compare-write on one bucket row per word.
    bks_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_valid(op_valid),
        .o_op_ready(op_ready),
        .i_op      (op),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_found   (o_found),
        .o_status  (o_status)
    );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the bucketed key set: random and directed traffic checked against a model.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds a model of the key table and the queue of predicted responses.
class key_set_scoreboard;
    typedef struct packed {
        logic found;
        logic status;
    } t_reply;

    logic [255:0] slot_key [bks_pkg::BUCKETS*bks_pkg::WAYS];
    bit           slot_used [bks_pkg::BUCKETS*bks_pkg::WAYS];
    t_reply       pending_replies [$];
    int           error_count;
    int           checked;

    function new();
        foreach (slot_used[i]) slot_used[i] = 0;
        error_count = 0;
        checked = 0;
    endfunction

    // Apply one accepted word to the model and queue the reply it produces.
    function void note_word(bks_pkg::t_cmd cmd, logic [255:0] key);
        int     base;
        int     hit_way;
        int     free_way;
        t_reply r;
        base = int'(key[255 -: bks_pkg::BUCKET_BITS]) * bks_pkg::WAYS;
        hit_way = -1;
        free_way = -1;
        r = '0;
        if (cmd == bks_pkg::CMD_CLEAR) begin
            foreach (slot_used[i]) slot_used[i] = 0;
        end else begin
            for (int w = 0; w < bks_pkg::WAYS; w++) begin
                if (slot_used[base+w]) begin
                    if (hit_way < 0 && slot_key[base+w] == key) hit_way = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            r.found = (hit_way >= 0);
            if (cmd == bks_pkg::CMD_INSERT && hit_way < 0) begin
                if (free_way >= 0) begin
                    slot_key[base+free_way] = key;
                    slot_used[base+free_way] = 1;
                end else begin
                    r.status = 1;
                end
            end else if (cmd == bks_pkg::CMD_REMOVE && hit_way >= 0) begin
                slot_used[base+hit_way] = 0;
            end
        end
        pending_replies.push_back(r);
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        error_count++;
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_reply(logic found, logic status);
        t_reply e;
        checked++;
        if (pending_replies.size() == 0) begin
            report("response with nothing expected");
        end else begin
            e = pending_replies.pop_front();
            if (found !== e.found)
                report($sformatf("found %b, expected %b (reply %0d)", found, e.found, checked));
            if (status !== e.status)
                report($sformatf("status %b, expected %b (reply %0d)", status, e.status, checked));
        end
    endfunction
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_command = '0;
    logic [63:0] i_key_w0 = '0;
    logic [63:0] i_key_w1 = '0;
    logic [63:0] i_key_w2 = '0;
    logic [63:0] i_key_w3 = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic        o_found;
    logic        o_status;

    key_set_scoreboard board = new();

    // Knobs that shape both sides' idling.
    bit          calm = 0;        // no idling at all while set
    bit          hold_off = 0;    // receiver refuses everything while set
    int          cycle_count = 0;
    int          sent = 0;
    int          inserts_full = 0;

    // Recently used keys, reused so that lookups and removes hit.
    logic [255:0] key_pool [$];

    bucketed_key_set_unit u_top (.*);

    always #2 i_clk = ~i_clk;

    // Run guard: the slowest run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver: random readiness, sampled on the same edge the block sees.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_reply(o_found, o_status);
            if (o_status) inserts_full <= inserts_full + 1;
        end
        i_ready <= !hold_off && (calm || $urandom_range(99) >= 32);
    end

    // Send one word; valid stays high until it is taken. The next call either
    // replaces the payload or drops valid, so valid is touched once per edge.
    task automatic send_word(bks_pkg::t_cmd cmd, logic [255:0] key);
        while (!calm && $urandom_range(99) < 32) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid   <= 1;
        i_command <= cmd;
        {i_key_w0, i_key_w1, i_key_w2, i_key_w3} <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_word(cmd, key);
        sent++;
    endtask

    // Key in a small set of buckets, so buckets fill and keys collide.
    function automatic logic [255:0] random_key();
        logic [255:0] k;
        k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0)
            k[255 -: bks_pkg::BUCKET_BITS] = bks_pkg::BUCKET_BITS'($urandom_range(3));
        if ($urandom_range(3) == 0) k[247:0] = 248'($urandom_range(7));
        return k;
    endfunction

    function automatic logic [255:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(1))
            return key_pool[$urandom_range(key_pool.size()-1)];
        return random_key();
    endfunction

    logic [255:0]  k;
    logic [255:0]  fill_key;
    bks_pkg::t_cmd c;
    int            r;

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: extreme keys, every command, full bucket, duplicate,
        // absent remove and a clear.
        calm = 1;
        send_word(bks_pkg::CMD_LOOKUP, '0);
        send_word(bks_pkg::CMD_INSERT, '0);
        send_word(bks_pkg::CMD_INSERT, '0);
        send_word(bks_pkg::CMD_INSERT, '1);
        send_word(bks_pkg::CMD_LOOKUP, '1);
        send_word(bks_pkg::CMD_REMOVE, '1);
        send_word(bks_pkg::CMD_REMOVE, '1);
        send_word(bks_pkg::CMD_LOOKUP, '1);
        for (int i = 1; i <= bks_pkg::WAYS + 1; i++) begin
            fill_key = '0;
            fill_key[0] = 1'b1;
            fill_key[255] = 1'b1;
            fill_key[8 +: 8] = 8'(i);
            send_word(bks_pkg::CMD_INSERT, fill_key);
        end
        send_word(bks_pkg::CMD_LOOKUP, fill_key);
        fill_key[8 +: 8] = 8'd1;
        send_word(bks_pkg::CMD_REMOVE, fill_key);
        fill_key[8 +: 8] = 8'(bks_pkg::WAYS + 1);
        send_word(bks_pkg::CMD_INSERT, fill_key);
        send_word(bks_pkg::CMD_CLEAR, '1);
        send_word(bks_pkg::CMD_LOOKUP, '0);
        send_word(bks_pkg::CMD_LOOKUP, fill_key);

        // Pressure: the receiver stalls long while words keep coming.
        fork
            begin
                hold_off = 1;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 8; i++) send_word(bks_pkg::CMD_INSERT, random_key());
                i_valid <= 0;
                @(posedge i_clk);
            end
        join
        calm = 0;

        // Random part: mostly inserts and lookups on reused keys.
        for (int i = 0; i < 1000; i++) begin
            if (i == 400) calm = 1;
            if (i == 550) calm = 0;
            r = $urandom_range(99);
            c = (r < 40) ? bks_pkg::CMD_INSERT : (r < 70) ? bks_pkg::CMD_LOOKUP :
                (r < 98) ? bks_pkg::CMD_REMOVE : bks_pkg::CMD_CLEAR;
            k = pick_key();
            if (c == bks_pkg::CMD_INSERT) begin
                key_pool.push_back(k);
                if (key_pool.size() > 64) void'(key_pool.pop_front());
            end
            send_word(c, k);
        end
        i_valid <= 0;

        // Drain, then let the block settle.
        while (board.pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d words, %0d replies, %0d inserts into full buckets",
                 sent, board.checked, inserts_full);
        if (board.error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/bks_pkg.sv
rtl/bks_ram.sv
rtl/bks_front.sv
rtl/bks_back.sv
rtl/bucketed_key_set_unit.sv
tb/testbench.sv
